/* hdl/lru_page_replacement_macros.svh */
// ----------------------------------------------------------------------------
// lru_page_replacement_macros.svh
// Assertion shorthands shared by the page replacement unit
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LRU_PR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LRU_PR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lru_pr_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared codes and the scan / update records passed along the frame cells
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  // widest page number and frame index the unit is built for
  localparam int PAGE_W_MAX = 32;
  localparam int IDX_W_MAX  = 6;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // item operation codes
  localparam logic OP_REF   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // search record that walks the chain, one cell per cycle
  typedef struct packed {
    logic                  run;
    logic                  clear;
    logic [PAGE_W_MAX-1:0] page;
    logic                  hit;
    logic [IDX_W_MAX-1:0]  hit_idx;
    logic [IDX_W_MAX-1:0]  hit_rank;
    logic                  empty_found;
    logic [IDX_W_MAX-1:0]  empty_idx;
    logic [IDX_W_MAX-1:0]  best_rank;
    logic [IDX_W_MAX-1:0]  best_idx;
    logic [PAGE_W_MAX-1:0] best_tag;
  } scan_t;

  // update broadcast to every cell when an item finishes
  typedef struct packed {
    logic                  apply;
    logic                  clear;
    logic                  fill;
    logic                  limited;
    logic [IDX_W_MAX-1:0]  slot;
    logic [IDX_W_MAX-1:0]  limit;
    logic [PAGE_W_MAX-1:0] page;
  } upd_t;

endpackage

/* hdl/lru_pr_cell.sv */
// ----------------------------------------------------------------------------
// lru_pr_cell
// One page frame: holds tag, valid and recency rank, folds itself into the
// passing search record and applies the broadcast update
// ----------------------------------------------------------------------------
module lru_pr_cell #(
  parameter int IDX       = 0,
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(FRAMES+1)-1:0]  active,
  input  lru_pr_pkg::scan_t            scan_in,
  output lru_pr_pkg::scan_t            scan_out,
  input  lru_pr_pkg::upd_t             upd
);

  localparam int CW = $clog2(FRAMES + 1);
  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [PAGE_BITS-1:0]             tag;
  logic                             valid;
  logic [RW-1:0]                    rank;
  logic                             act;
  logic                             is_slot;
  logic [lru_pr_pkg::IDX_W_MAX-1:0] rank_ext;
  lru_pr_pkg::scan_t                scan_next;

  assign act      = CW'(IDX) < active;
  assign is_slot  = upd.slot == lru_pr_pkg::IDX_W_MAX'(IDX);
  assign rank_ext = lru_pr_pkg::IDX_W_MAX'(rank);

  // fold this frame into the search record
  always_comb begin
    scan_next = scan_in;
    if (act && valid && !scan_in.hit && tag == PAGE_BITS'(scan_in.page)) begin
      scan_next.hit      = 1'b1;
      scan_next.hit_idx  = lru_pr_pkg::IDX_W_MAX'(IDX);
      scan_next.hit_rank = rank_ext;
    end
    if (act && !valid && !scan_in.empty_found) begin
      scan_next.empty_found = 1'b1;
      scan_next.empty_idx   = lru_pr_pkg::IDX_W_MAX'(IDX);
    end
    // frame 0 seeds the victim, later frames win only on a strictly older rank
    if (act && (IDX == 0 || rank_ext > scan_in.best_rank)) begin
      scan_next.best_rank = rank_ext;
      scan_next.best_idx  = lru_pr_pkg::IDX_W_MAX'(IDX);
      scan_next.best_tag  = lru_pr_pkg::PAGE_W_MAX'(tag);
    end
  end

  // hand the record to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

  // frame state: clear, touch as most recent, or age
  always_ff @(posedge clk) begin
    if (rst || (upd.apply && upd.clear)) begin
      valid <= 1'b0;
      rank  <= '0;
      tag   <= '0;
    end else if (upd.apply) begin
      if (is_slot) begin
        rank <= '0;
        if (upd.fill) begin
          tag   <= PAGE_BITS'(upd.page);
          valid <= 1'b1;
        end
      end else if (act && valid && (!upd.limited || rank_ext < upd.limit) &&
                   rank != RW'(FRAMES - 1)) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

/* hdl/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page replacement unit built as a chain of frame cells
// ----------------------------------------------------------------------------
// Each item references a page or clears all frames and counters, and gives one
// result: hit, frame index, the evicted page and saturating hit / miss totals.
// A search record enters frame 0 and moves one frame cell per clock. An item
// passes down the cell chain, then the finished search is latched, then all
// frames are updated and the result register is loaded once the output is
// free, and the sequencer returns to idle to take the next transfer.
// The result register lets the next item start while a result waits.
// frames_in_use is clamped to 1..FRAMES; write it only while idle.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [3:0]           cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [2:0]           frame_index,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total
);

  localparam int CW = $clog2(FRAMES + 1);
  localparam int AW = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t                           state;
  logic [3:0]                       frames_in_use;
  logic [AW-1:0]                    fiu_wide;
  logic [CW-1:0]                    active;
  lru_pr_pkg::scan_t                chain [FRAMES+1];
  lru_pr_pkg::scan_t                seed;
  lru_pr_pkg::scan_t                fin;
  lru_pr_pkg::upd_t                 upd;
  logic [31:0]                      hit_cnt;
  logic [31:0]                      miss_cnt;
  logic                             in_xfer;
  logic                             out_free;
  logic [lru_pr_pkg::IDX_W_MAX-1:0] slot;

  assign in_ready = !rst && state == S_IDLE;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 4'd8;
    end else if (cfg_write_en) begin
      frames_in_use <= cfg_write_data;
    end
  end

  // clamp the active frame count to 1..FRAMES
  always_comb begin
    fiu_wide = AW'(frames_in_use);
    if (fiu_wide == '0) begin
      active = CW'(1);
    end else if (fiu_wide > AW'(FRAMES)) begin
      active = CW'(FRAMES);
    end else begin
      active = CW'(fiu_wide);
    end
  end

  // search record for a new item
  always_comb begin
    seed       = '0;
    seed.run   = 1'b1;
    seed.clear = opcode == lru_pr_pkg::OP_CLEAR;
    seed.page  = lru_pr_pkg::PAGE_W_MAX'(page);
  end

  // seed the search record on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else if (in_xfer) begin
      chain[0] <= seed;
    end else begin
      chain[0] <= '0;
    end
  end

  // frame cells
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lru_pr_cell #(
      .IDX       (i),
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .active   (active),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .upd      (upd)
    );
  end

  // chosen frame: hit, else first empty, else oldest
  always_comb begin
    if (fin.hit) begin
      slot = fin.hit_idx;
    end else if (fin.empty_found) begin
      slot = fin.empty_idx;
    end else begin
      slot = fin.best_idx;
    end
  end

  // update broadcast
  always_comb begin
    upd.apply   = (state == S_FIN) && out_free;
    upd.clear   = fin.clear;
    upd.fill    = !fin.hit;
    upd.limited = fin.hit;
    upd.slot    = slot;
    upd.limit   = fin.hit_rank;
    upd.page    = fin.page;
  end

  // sequencer, finished search and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[FRAMES].run) begin
            fin   <= chain[FRAMES];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
            if (fin.clear) begin
              hit           <= 1'b0;
              frame_index   <= '0;
              evicted_valid <= 1'b0;
              evicted_page  <= '0;
              hit_cnt       <= '0;
              miss_cnt      <= '0;
            end else begin
              hit           <= fin.hit;
              frame_index   <= slot[2:0];
              evicted_valid <= !fin.hit && !fin.empty_found;
              evicted_page  <= (!fin.hit && !fin.empty_found) ?
                               PAGE_BITS'(fin.best_tag) : '0;
              if (fin.hit) begin
                if (hit_cnt != lru_pr_pkg::CNT_MAX) begin
                  hit_cnt <= hit_cnt + 32'd1;
                end
              end else if (miss_cnt != lru_pr_pkg::CNT_MAX) begin
                miss_cnt <= miss_cnt + 32'd1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign hit_total  = hit_cnt;
  assign miss_total = miss_cnt;

  // checks
`include "lru_page_replacement_macros.svh"

  `LRU_PR_ASSERT_NOW(a_no_evict_on_hit, out_valid, !(hit && evicted_valid), "eviction reported on a hit")
  `LRU_PR_ASSERT_NEXT(a_hit_keeps_miss, upd.apply && !fin.clear && fin.hit, miss_cnt == $past(miss_cnt), "miss count moved on a hit")
  `LRU_PR_ASSERT_NEXT(a_miss_keeps_hit, upd.apply && !fin.clear && !fin.hit, hit_cnt == $past(hit_cnt), "hit count moved on a miss")
  `LRU_PR_ASSERT_NOW(a_scan_only_busy, chain[FRAMES].run, state == S_SCAN, "search finished outside a scan")

endmodule
